// ----- hdl/ple_pkg.sv -----
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int POS_W   = 9;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 9;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic get_rd;
        logic put_word;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic is_get;
        logic is_insert;
        logic is_delete;
        logic no_moves;
        logic last_step;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/positional_list_engine.sv -----
// Every item passes IDLE, where it is taken, then EVAL and FIN; a get, a clear or a failing
// item goes from EVAL straight to FIN. An insert or delete that moves words adds SHIFT and
// DRAIN, and an insert also adds PUT. A tail delete or an append moves no words. The shift
// walk moves one word per cycle through the single read and single write port of the
// list memory. One item is in work at a time; the next is taken while a result waits.
// Reset (synchronous, active low) empties the list; the memory is not cleared.
`timescale 1ns / 1ps

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_operation,
    input  logic [ple_pkg::POS_W-1:0]           i_position,
    input  logic signed [ple_pkg::WORD_W-1:0]   i_write_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic signed [ple_pkg::WORD_W-1:0]   o_read_data,
    output logic [ple_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_is_empty
);
    import ple_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ple_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_write_data  (i_write_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

endmodule

// ----- hdl/ple_datapath.sv -----
`timescale 1ns / 1ps

module ple_datapath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ple_pkg::t_dp_cmd                    i_cmd,
    output ple_pkg::t_dp_status                 o_status,
    input  logic [1:0]                          i_operation,
    input  logic [ple_pkg::POS_W-1:0]           i_position,
    input  logic signed [ple_pkg::WORD_W-1:0]   i_write_data,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic signed [ple_pkg::WORD_W-1:0]   o_read_data,
    output logic [ple_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_is_empty
);
    import ple_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic signed [WORD_W-1:0] r_mem [CAPACITY];

    logic [1:0]               r_op;
    logic [POS_W-1:0]         r_pos;
    logic signed [WORD_W-1:0] r_data;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [AW-1:0]            r_ptr;
    logic [AW-1:0]            n_ptr;
    logic signed [WORD_W-1:0] r_rd_data;
    logic                     r_wr_pend;
    logic [AW-1:0]            r_wr_addr;
    logic                     r_out_valid;
    logic                     r_out_ok;
    logic signed [WORD_W-1:0] r_out_data;
    logic [CW-1:0]            r_out_count;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [AW-1:0]   pos_idx;
    logic [AW-1:0]   cnt_last;
    logic [AW-1:0]   rd_addr;
    logic            ok;
    logic            is_get;
    logic            is_insert;
    logic            is_delete;

    assign pos_ext   = CMPW'(r_pos);
    assign cnt_ext   = CMPW'(r_count);
    assign pos_idx   = AW'(pos_ext - CMPW'(1));
    assign cnt_last  = AW'(cnt_ext - CMPW'(1));
    assign is_get    = (r_op == OP_GET);
    assign is_insert = (r_op == OP_INSERT);
    assign is_delete = (r_op == OP_DELETE);

    always_comb begin
        case (r_op)
            OP_GET, OP_DELETE: begin
                ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
            end
            OP_INSERT: begin
                ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1))
                     && (cnt_ext < CMPW'(CAPACITY));
            end
            default: begin
                ok = 1'b1;
            end
        endcase
    end

    assign o_status.ok        = ok;
    assign o_status.is_get    = is_get;
    assign o_status.is_insert = is_insert;
    assign o_status.is_delete = is_delete;
    assign o_status.no_moves  = is_insert ? (pos_ext == cnt_ext + CMPW'(1))
                                          : (pos_ext == cnt_ext);
    assign o_status.last_step = is_insert ? (r_ptr == pos_idx) : (r_ptr == cnt_last);
    assign o_status.out_free  = !r_out_valid || !i_stall;

    // Insert walks down from the tail, delete walks up from the hole.
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.start) begin
            n_ptr = is_insert ? cnt_last : AW'(r_pos);
        end else if (i_cmd.step) begin
            n_ptr = is_insert ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
        end
    end

    assign rd_addr = i_cmd.get_rd ? pos_idx : r_ptr;

    always_comb begin
        n_count = r_count;
        if (ok) begin
            case (r_op)
                OP_INSERT: n_count = r_count + CW'(1);
                OP_DELETE: n_count = r_count - CW'(1);
                OP_CLEAR:  n_count = '0;
                default:   n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step || i_cmd.get_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // A word read by one step is written one place over in the next cycle.
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= r_rd_data;
        end else if (i_cmd.put_word) begin
            r_mem[pos_idx] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_pos  <= i_position;
            r_data <= i_write_data;
        end
        r_ptr     <= n_ptr;
        r_wr_addr <= is_insert ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
        if (i_cmd.finish) begin
            r_out_ok    <= ok;
            r_out_data  <= (ok && is_get) ? r_rd_data : '0;
            r_out_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.step;
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_read_data   = r_out_data;
    assign o_entry_count = COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);

endmodule

// ----- hdl/ple_controller.sv -----
`timescale 1ns / 1ps

module ple_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ple_pkg::t_dp_status i_status,
    output ple_pkg::t_dp_cmd    o_cmd
);
    import ple_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_status.ok) begin
                    n_state = S_FIN;
                end else if (i_status.is_get) begin
                    o_cmd.get_rd = 1'b1;
                    n_state      = S_FIN;
                end else if (i_status.is_insert) begin
                    if (i_status.no_moves) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else if (i_status.is_delete) begin
                    if (i_status.no_moves) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last moved word is written during this cycle.
                n_state = i_status.is_insert ? S_PUT : S_FIN;
            end
            S_PUT: begin
                o_cmd.put_word = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- hdl/ple_checker.sv -----
`timescale 1ns / 1ps

module ple_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_ok,
    input logic signed [ple_pkg::WORD_W-1:0] o_read_data,
    input logic [ple_pkg::COUNT_W-1:0]       o_entry_count,
    input logic                              o_is_empty
);

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_read_data == '0))
        else $error("failed item returned nonzero read data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an accepted item");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data)
                                  && $stable(o_entry_count) && $stable(o_ok)))
        else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_ok          (o_ok),
    .o_read_data   (o_read_data),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);
